/* hw/rtl/multi_stepper_pulse_generator_defines.svh */
// assertion macros for the stepper pulse generator
`ifndef MULTI_STEPPER_PULSE_GENERATOR_DEFINES_SVH
`define MULTI_STEPPER_PULSE_GENERATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MSPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define MSPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/mspg_pkg.sv */
// shared types and constants for the stepper pulse generator
`timescale 1ns / 1ps
package mspg_pkg;
  localparam int Motors = 8;
  localparam int MotW = 3;

  localparam logic [3:0] K_BASE = 4'd0;
  localparam logic [3:0] K_MS = 4'd1;
  localparam logic [3:0] K_RUN = 4'd2;
  localparam logic [3:0] K_STOPC = 4'd3;
  localparam logic [3:0] K_LIMIT = 4'd4;
  localparam logic [3:0] K_LREP = 4'd5;
  localparam logic [3:0] K_SPEED = 4'd6;
  localparam logic [3:0] K_WAKE = 4'd7;
  localparam logic [3:0] K_SLEEP = 4'd8;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_RUN = 2'd2;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_NORMAL = 2'd1;
  localparam logic [1:0] CAUSE_LIMIT = 2'd2;

  localparam logic [1:0] REP_NORMAL = 2'd0;
  localparam logic [1:0] REP_LIMIT = 2'd1;
  localparam logic [1:0] REP_BUSY = 2'd2;

  localparam logic [2:0] CFG_CONT = 3'd0;
  localparam logic [2:0] CFG_NOSLEEP = 3'd1;
  localparam logic [2:0] CFG_DIRPOL = 3'd2;
  localparam logic [2:0] CFG_DEFDIV = 3'd3;
  localparam logic [2:0] CFG_SLEEPTO = 3'd4;
  localparam logic [2:0] CFG_ENDELAY = 3'd5;

  // one motor's record as held in the state memory
  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  cause;
    logic [31:0] target;
    logic [31:0] count;
    logic        half;
    logic [15:0] reload;
    logic [15:0] tick;
    logic [15:0] idle;
    logic [3:0]  wait_cnt;
    logic        wake;
  } motor_rec_t;

  typedef struct packed {
    logic [7:0] cont;
    logic [7:0] nosleep;
    logic [7:0] dirpol;
    logic [15:0] defdiv;
    logic [15:0] sleepto;
    logic [3:0] endelay;
  } cfg_t;

  function automatic logic [15:0] clamp_div(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction
endpackage

/* hw/rtl/multi_stepper_pulse_generator.sv */
// top level: command sequencer over the per-motor state memory
// result: a command's result word is registered in S_EMIT, after S_READ and S_MOD;
//   ticks walk all motors, a read and a modify step per motor, then S_EMIT
// flow: the next command is taken in S_IDLE, after the last result; a tick gives one
//   more result word per extra stop report; the read-modify-write pass sets the rate
// reset: a clearing pass writes every motor record; start is held off meanwhile
`timescale 1ns / 1ps
`include "multi_stepper_pulse_generator_defines.svh"
module multi_stepper_pulse_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_kind,
  input  logic [2:0]  in_motor,
  input  logic        in_direction,
  input  logic [31:0] in_steps,
  input  logic [15:0] in_divider,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic [7:0]  out_clk_levels,
  output logic [7:0]  out_dir_levels,
  output logic [7:0]  out_enable_n_levels,
  output logic [7:0]  out_running_mask,
  output logic        out_report_valid,
  output logic [2:0]  out_report_motor,
  output logic [1:0]  out_report_kind,
  output logic        out_last
);
  import mspg_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_MOD, S_EMIT, S_DONE} st_t;
  st_t st_r;

  cfg_t cfg_r;
  logic [3:0] kind_r;
  logic [2:0] mot_r;
  logic dir_r;
  logic [31:0] steps_r;
  logic [15:0] div_r;
  logic [MotW:0] idx_r;      // walk index, one bit wider to hold the end
  logic [7:0] clk_r, dirp_r, en_r, run_r;
  logic [7:0] done_r;        // motors that finished during a base tick
  logic rep_r;
  logic [1:0] rep_kind_r;
  logic [7:0] spd_set_r, spd_set_nxt;  // motors whose reload came from set speed

  logic we;
  logic [MotW-1:0] waddr, raddr;
  motor_rec_t wdata, rd;

  mspg_state_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                        .raddr(raddr), .rdata(rd));

  wire walk = (kind_r == K_BASE) || (kind_r == K_MS);
  wire [MotW-1:0] cur = (walk || st_r == S_CLEAR) ? idx_r[MotW-1:0] : mot_r;
  assign raddr = cur;
  assign waddr = cur;

  assign busy = (st_r != S_IDLE);
  assign cfg_ready = (st_r != S_CLEAR);

  // reload falls back to the default divider until set speed writes it
  logic [15:0] rl;
  assign rl = spd_set_r[cur] ? rd.reload : cfg_r.defdiv;

  // a default divider write drops every set-speed override
  always_comb begin
    spd_set_nxt = spd_set_r;
    if (st_r == S_MOD && kind_r == K_SPEED) spd_set_nxt[cur] = 1'b1;
    if (cfg_valid && cfg_ready && cfg_index == CFG_DEFDIV) spd_set_nxt = '0;
  end

  // per-motor modify step, combinational on the registered read
  motor_rec_t nr;
  logic [7:0] clk_n, dir_n, en_n, run_n, done_n;
  logic rep_n;
  logic [1:0] rk_n;
  logic b;
  always_comb begin
    nr = rd;
    clk_n = clk_r; dir_n = dirp_r; en_n = en_r; run_n = run_r; done_n = done_r;
    rep_n = rep_r; rk_n = rep_kind_r;
    b = 1'b0;
    we = 1'b0;
    if (st_r == S_CLEAR) begin
      nr = '0;
      we = 1'b1;
    end else if (st_r == S_MOD) begin
      we = 1'b1;
      unique case (kind_r)
        K_BASE: begin
          if (rd.phase == PH_RUN) begin
            if (rd.tick > 16'd1) nr.tick = rd.tick - 16'd1;
            else begin
              nr.tick = rl;
              clk_n[cur] = ~clk_r[cur];
              if (!cfg_r.cont[cur]) begin
                if (!rd.half) nr.half = 1'b1;
                else begin
                  nr.half = 1'b0;
                  nr.count = rd.count + 32'd1;
                  if (nr.count >= rd.target) begin
                    nr.phase = PH_IDLE; clk_n[cur] = 1'b0;
                    nr.count = '0; nr.tick = '0; nr.idle = '0;
                    if (rd.cause == CAUSE_NONE) nr.cause = CAUSE_NORMAL;
                    done_n[cur] = 1'b1;
                  end
                end
              end
            end
          end
        end
        K_MS: begin
          if (rd.phase == PH_IDLE) begin
            if (rd.idle != 16'hFFFF) nr.idle = rd.idle + 16'd1;
            if (!cfg_r.nosleep[cur] && !rd.wake && !en_r[cur] &&
                nr.idle >= cfg_r.sleepto) begin
              en_n[cur] = 1'b1; clk_n[cur] = 1'b0;
            end
          end else if (rd.phase == PH_WAIT) begin
            if (rd.wait_cnt != 4'd0) nr.wait_cnt = rd.wait_cnt - 4'd1;
            if (nr.wait_cnt == 4'd0) begin nr.tick = rl; nr.phase = PH_RUN; end
          end
        end
        K_RUN: begin
          if (steps_r != 32'd0) begin
            if (rd.phase != PH_IDLE) begin rep_n = 1'b1; rk_n = REP_BUSY; end
            else begin
              nr.target = steps_r; nr.phase = PH_WAIT; nr.cause = CAUSE_NONE;
              nr.half = 1'b0; nr.count = '0; nr.wake = 1'b0;
              dir_n[cur] = cfg_r.dirpol[cur] ^ dir_r;
              en_n[cur] = 1'b0;
              nr.wait_cnt = cfg_r.endelay;
              if (cfg_r.endelay == 4'd0) begin nr.tick = rl; nr.phase = PH_RUN; end
            end
          end
        end
        K_STOPC, K_LIMIT: begin
          b = (kind_r == K_STOPC) ? cfg_r.cont[cur] : (rd.phase != PH_IDLE);
          if (b) begin
            if (rd.phase == PH_WAIT) en_n[cur] = 1'b1;
            nr.phase = PH_IDLE; clk_n[cur] = 1'b0;
            nr.half = 1'b0; nr.count = '0; nr.tick = '0; nr.idle = '0;
            if (kind_r == K_LIMIT) nr.cause = CAUSE_LIMIT;
          end
        end
        K_LREP: begin
          if (rd.cause == CAUSE_LIMIT) begin rep_n = 1'b1; rk_n = REP_LIMIT; end
        end
        K_SPEED: begin
          nr.reload = clamp_div(div_r);
        end
        K_WAKE: begin
          nr.wake = 1'b1; clk_n[cur] = 1'b0; en_n[cur] = 1'b0; nr.idle = '0;
        end
        K_SLEEP: begin
          if (rd.phase == PH_IDLE) begin
            nr.wake = 1'b0; en_n[cur] = 1'b1; clk_n[cur] = 1'b0;
          end
        end
        default: we = 1'b0;
      endcase
      run_n[cur] = (nr.phase == PH_RUN);
    end
  end
  assign wdata = nr;

  // lowest pending finished motor
  logic [2:0] first_done;
  logic more_done;
  always_comb begin
    first_done = '0;
    for (int i = 7; i >= 0; i--) if (done_r[i]) first_done = 3'(i);
    more_done = ((done_r & (done_r - 8'd1)) != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      idx_r <= '0;
      cfg_r <= '{cont: 8'd0, nosleep: 8'd0, dirpol: 8'd0, defdiv: 16'd100,
                 sleepto: 16'd3000, endelay: 4'd5};
      clk_r <= '0; dirp_r <= '0; en_r <= 8'hFF; run_r <= '0;
      done_r <= '0; rep_r <= 1'b0; rep_kind_r <= REP_NORMAL;
      spd_set_r <= '0;
      out_strobe <= 1'b0;
      kind_r <= K_SPEED;
    end else begin
      out_strobe <= 1'b0;
      spd_set_r <= spd_set_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CONT:    cfg_r.cont <= cfg_data[7:0];
          CFG_NOSLEEP: cfg_r.nosleep <= cfg_data[7:0];
          CFG_DIRPOL:  cfg_r.dirpol <= cfg_data[7:0];
          CFG_DEFDIV:  cfg_r.defdiv <= clamp_div(cfg_data[15:0]);
          CFG_SLEEPTO: cfg_r.sleepto <= cfg_data[15:0];
          CFG_ENDELAY: cfg_r.endelay <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_CLEAR: begin
          idx_r <= idx_r + (MotW+1)'(1);
          if (idx_r == (MotW+1)'(Motors - 1)) begin st_r <= S_IDLE; idx_r <= '0; end
        end
        S_IDLE: if (start) begin
          kind_r <= in_kind; mot_r <= in_motor; dir_r <= in_direction;
          steps_r <= in_steps; div_r <= in_divider;
          idx_r <= '0; done_r <= '0; rep_r <= 1'b0; rep_kind_r <= REP_NORMAL;
          st_r <= S_READ;
        end
        S_READ: st_r <= S_MOD;
        S_MOD: begin
          clk_r <= clk_n; dirp_r <= dir_n; en_r <= en_n; run_r <= run_n;
          done_r <= done_n; rep_r <= rep_n; rep_kind_r <= rk_n;
          if (walk && idx_r != (MotW+1)'(Motors - 1)) begin
            idx_r <= idx_r + (MotW+1)'(1); st_r <= S_READ;
          end else st_r <= S_EMIT;
        end
        S_EMIT: begin
          out_strobe <= 1'b1;
          out_clk_levels <= clk_r; out_dir_levels <= dirp_r;
          out_enable_n_levels <= en_r; out_running_mask <= run_r;
          if (done_r != 8'd0) begin
            out_report_valid <= 1'b1; out_report_motor <= first_done;
            out_report_kind <= REP_NORMAL; out_last <= !more_done;
            done_r[first_done] <= 1'b0;
            if (!more_done) st_r <= S_DONE;
          end else begin
            out_report_valid <= rep_r;
            out_report_motor <= rep_r ? mot_r : 3'd0;
            out_report_kind <= rep_r ? rep_kind_r : REP_NORMAL;
            out_last <= 1'b1;
            st_r <= S_DONE;
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MSPG_ASSERT_IMP(a_run_enabled, out_strobe, ((out_running_mask & out_enable_n_levels) == 8'd0))
  `MSPG_ASSERT_IMP(a_no_accept_busy, (st_r != S_IDLE), busy)
  `MSPG_ASSERT_NXT(a_strobe_only_emit, (st_r != S_EMIT), !out_strobe)
endmodule

/* hw/rtl/mspg_state_ram.sv */
// per-motor state memory, one write and one registered read port
`timescale 1ns / 1ps
module mspg_state_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [mspg_pkg::MotW-1:0] waddr,
  input  mspg_pkg::motor_rec_t    wdata,
  input  logic [mspg_pkg::MotW-1:0] raddr,
  output mspg_pkg::motor_rec_t    rdata
);
  import mspg_pkg::*;
  motor_rec_t mem [Motors];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
